[hdl/mi3_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

  localparam int W         = 32;
  localparam int PROD_W    = 64;
  localparam int DET_W     = 97;
  localparam int DIV_STEPS = 32;
  localparam int REM_W     = PROD_W + DIV_STEPS;
  localparam int DSH_W     = DET_W + DIV_STEPS;
  localparam int FRONT     = 6;
  localparam int LAST      = FRONT + DIV_STEPS;
  localparam int NSTG      = LAST + 1;

  localparam logic [W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [PROD_W-1:0] mc;
    logic [DET_W-1:0]  dm;
    logic              neg;
    logic              zero;
    logic              sat;
  } div_in_t;

endpackage

[hdl/matrix3_inverse.sv]
// Top level of the 3x3 matrix inverse pipeline.
// Inverts one signed Q16.16 3x3 matrix per request through the adjugate and the exact
// determinant. One request enters per clock while req_stall is low. Six stages form the
// products, cofactors and determinant; nine parallel restoring dividers then take one
// quotient bit per stage for 32 stages, and a last stage rounds, saturates and holds the
// result. Stalls collapse bubbles stage by stage. A zero determinant gives all-zero
// elements with singular set; a saturated element sets overflowed.
module matrix3_inverse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic signed [mi3_pkg::W-1:0] a00,
  input  logic signed [mi3_pkg::W-1:0] a01,
  input  logic signed [mi3_pkg::W-1:0] a02,
  input  logic signed [mi3_pkg::W-1:0] a10,
  input  logic signed [mi3_pkg::W-1:0] a11,
  input  logic signed [mi3_pkg::W-1:0] a12,
  input  logic signed [mi3_pkg::W-1:0] a20,
  input  logic signed [mi3_pkg::W-1:0] a21,
  input  logic signed [mi3_pkg::W-1:0] a22,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [mi3_pkg::W-1:0] b00,
  output logic signed [mi3_pkg::W-1:0] b01,
  output logic signed [mi3_pkg::W-1:0] b02,
  output logic signed [mi3_pkg::W-1:0] b10,
  output logic signed [mi3_pkg::W-1:0] b11,
  output logic signed [mi3_pkg::W-1:0] b12,
  output logic signed [mi3_pkg::W-1:0] b20,
  output logic signed [mi3_pkg::W-1:0] b21,
  output logic signed [mi3_pkg::W-1:0] b22,
  output logic                         singular,
  output logic                         overflowed
);
  import mi3_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !res_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= req_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign req_stall = !adv[0];
  assign res_valid = vld[NSTG-1];

  // stage 0: element products
  logic signed [PROD_W-1:0] p [18];
  logic signed [W-1:0]      r0 [3];
  logic signed [W-1:0]      r1 [3];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p[0]  <= a11 * a22;  p[1]  <= a12 * a21;
      p[2]  <= a02 * a21;  p[3]  <= a01 * a22;
      p[4]  <= a01 * a12;  p[5]  <= a02 * a11;
      p[6]  <= a12 * a20;  p[7]  <= a10 * a22;
      p[8]  <= a00 * a22;  p[9]  <= a02 * a20;
      p[10] <= a02 * a10;  p[11] <= a00 * a12;
      p[12] <= a10 * a21;  p[13] <= a11 * a20;
      p[14] <= a01 * a20;  p[15] <= a00 * a21;
      p[16] <= a00 * a11;  p[17] <= a01 * a10;
      r0[0] <= a00;
      r0[1] <= a01;
      r0[2] <= a02;
    end
  end

  // stage 1: cofactors
  logic signed [PROD_W-1:0] c1 [9];
  logic signed [PROD_W-1:0] c2 [9];
  logic signed [PROD_W-1:0] c3 [9];
  logic signed [PROD_W-1:0] c4 [9];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 9; i++) begin
        c1[i] <= p[2*i] - p[2*i+1];
      end
      r1 <= r0;
    end
  end

  // stage 2: determinant partial products, cofactor split in 32-bit halves
  logic signed [PROD_W-1:0] hp [3];
  logic signed [PROD_W-1:0] lp [3];
  logic signed [W:0]        lo_ext [3];
  logic signed [2*W+1:0]    lo_prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_ext[i]  = $signed({1'b0, c1[3*i][W-1:0]});
      lo_prod[i] = (2*W+2)'(lo_ext[i] * (W+1)'(r1[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        hp[i] <= r1[i] * $signed(c1[3*i][PROD_W-1:W]);
        lp[i] <= lo_prod[i][PROD_W-1:0];
      end
      c2 <= c1;
    end
  end

  // stage 3: three full products
  logic signed [DET_W-1:0] dp [3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        dp[i] <= (DET_W'(hp[i]) <<< W) + DET_W'(lp[i]);
      end
      c3 <= c2;
    end
  end

  // stage 4: determinant
  logic signed [DET_W-1:0] det;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      det <= dp[0] + dp[1] + dp[2];
      c4  <= c3;
    end
  end

  // stage 5: magnitudes, signs and early saturation
  div_in_t          dnext [9];
  div_in_t          dreg  [9];
  logic [DET_W-1:0] dmag;
  logic             dzero;

  always_comb begin
    dmag  = det[DET_W-1] ? (DET_W'(0) - det) : det;
    dzero = det == '0;
    for (int i = 0; i < 9; i++) begin
      dnext[i].mc   = c4[i][PROD_W-1] ? (PROD_W'(0) - c4[i]) : c4[i];
      dnext[i].dm   = dmag;
      dnext[i].neg  = c4[i][PROD_W-1] ^ det[DET_W-1];
      dnext[i].zero = dzero || (c4[i] == '0);
      dnext[i].sat  = (dmag[DET_W-1:PROD_W] == '0) && (dnext[i].mc >= dmag[PROD_W-1:0]);
    end
  end

  logic [DIV_STEPS+1:0] sing_pipe;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dreg         <= dnext;
      sing_pipe[0] <= dzero;
    end
    for (int j = 1; j <= DIV_STEPS + 1; j++) begin
      if (adv[FRONT+j-1]) begin
        sing_pipe[j] <= sing_pipe[j-1];
      end
    end
  end

  logic signed [W-1:0] bq  [9];
  logic [8:0]          ovf;

  for (genvar i = 0; i < 9; i++) begin : g_div
    mi3_divider u_div (
      .clk (clk),
      .en  (adv[LAST:FRONT]),
      .din (dreg[i]),
      .quo (bq[i]),
      .ovf (ovf[i])
    );
  end

  assign b00        = bq[0];
  assign b01        = bq[1];
  assign b02        = bq[2];
  assign b10        = bq[3];
  assign b11        = bq[4];
  assign b12        = bq[5];
  assign b20        = bq[6];
  assign b21        = bq[7];
  assign b22        = bq[8];
  assign singular   = sing_pipe[DIV_STEPS+1];
  assign overflowed = |ovf;

endmodule

[hdl/mi3_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, then round and saturate.
module mi3_divider (
  input  logic                         clk,
  input  logic [mi3_pkg::DIV_STEPS:0]  en,
  input  mi3_pkg::div_in_t             din,
  output logic signed [mi3_pkg::W-1:0] quo,
  output logic                         ovf
);
  import mi3_pkg::*;

  div_in_t              ctl [DIV_STEPS];
  logic [REM_W-1:0]     rem [DIV_STEPS];
  logic [DIV_STEPS-1:0] qb  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int B = DIV_STEPS - 1 - j;
    div_in_t              c_cur;
    logic [REM_W-1:0]     r_cur;
    logic [DIV_STEPS-1:0] q_cur;
    logic [REM_W-1:0]     shifted;
    logic [DSH_W-1:0]     dsh;
    logic                 ge;

    if (j == 0) begin : g_first
      assign c_cur = din;
      assign r_cur = {din.mc, {DIV_STEPS{1'b0}}};
      assign q_cur = '0;
    end else begin : g_rest
      assign c_cur = ctl[j-1];
      assign r_cur = rem[j-1];
      assign q_cur = qb[j-1];
    end

    always_comb begin
      shifted = r_cur >> B;
      ge      = {1'b0, shifted} >= c_cur.dm;
      dsh     = DSH_W'(c_cur.dm) << B;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        ctl[j] <= c_cur;
        rem[j] <= ge ? (r_cur - dsh[REM_W-1:0]) : r_cur;
        qb[j]  <= ge ? (q_cur | (DIV_STEPS'(1) << B)) : q_cur;
      end
    end
  end

  div_in_t          cl;
  logic             rnd;
  logic [W:0]       q33;
  logic             sat;
  logic [W-1:0]     res;

  always_comb begin
    cl  = ctl[DIV_STEPS-1];
    rnd = {rem[DIV_STEPS-1], 1'b0} >= cl.dm;
    q33 = {1'b0, qb[DIV_STEPS-1]} + (W+1)'(rnd);
    sat = cl.sat || (cl.neg ? (q33 > (W+1)'(SAT_NEG)) : (q33 > (W+1)'(SAT_POS)));
    if (cl.zero) begin
      res = '0;
    end else if (sat) begin
      res = cl.neg ? SAT_NEG : SAT_POS;
    end else if (cl.neg) begin
      res = W'(0) - q33[W-1:0];
    end else begin
      res = q33[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_STEPS]) begin
      quo <= res;
      ovf <= sat && !cl.zero;
    end
  end

endmodule

[tb/tb_matrix3_inverse.sv]
// Self-checking testbench for the 3x3 matrix inverse pipeline.
module tb_matrix3_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRAND = 1830;
  localparam int WDOG = 20000;

  typedef logic signed [31:0] elem_t;
  typedef struct {
    elem_t a [9];
  } mat_req_t;
  typedef struct {
    elem_t b [9];
    logic  sing;
    logic  ovf;
  } inv_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  elem_t a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0;
  elem_t a20 = '0, a21 = '0, a22 = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  elem_t b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic singular, overflowed;

  mat_req_t pending_reqs [$];
  inv_res_t expected_inv [$];
  int  errors = 0;
  int  idle_cycles = 0;

  matrix3_inverse uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic elem_t div_elem(logic signed [63:0] cof, logic signed [127:0] det,
                                     ref logic ovf);
    logic [127:0] dm, num, q, rem;
    logic [63:0]  mc;
    logic neg;
    mc  = cof < 0 ? -cof : cof;
    dm  = det < 0 ? -det : det;
    neg = (cof < 0) != (det < 0);
    if (mc == 0) return '0;
    num = {32'd0, mc, 32'd0};
    q   = num / dm;
    rem = num % dm;
    if ((rem << 1) >= dm) q = q + 1;
    if (neg ? (q > 128'h8000_0000) : (q > 128'h7FFF_FFFF)) begin
      ovf = 1'b1;
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return neg ? elem_t'(-q) : elem_t'(q);
  endfunction

  function automatic inv_res_t invert(mat_req_t m);
    inv_res_t r;
    logic signed [63:0] e [9];
    logic signed [63:0] c [9];
    logic signed [127:0] det;
    logic ovf;
    for (int i = 0; i < 9; i++) e[i] = m.a[i];
    c[0] = e[4]*e[8] - e[5]*e[7];
    c[1] = e[2]*e[7] - e[1]*e[8];
    c[2] = e[1]*e[5] - e[2]*e[4];
    c[3] = e[5]*e[6] - e[3]*e[8];
    c[4] = e[0]*e[8] - e[2]*e[6];
    c[5] = e[2]*e[3] - e[0]*e[5];
    c[6] = e[3]*e[7] - e[4]*e[6];
    c[7] = e[1]*e[6] - e[0]*e[7];
    c[8] = e[0]*e[4] - e[1]*e[3];
    det = 128'(e[0]) * 128'(c[0]) + 128'(e[1]) * 128'(c[3]) + 128'(e[2]) * 128'(c[6]);
    ovf = 1'b0;
    r.sing = (det == 0);
    for (int i = 0; i < 9; i++) r.b[i] = r.sing ? '0 : div_elem(c[i], det, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return elem_t'($urandom_range(0, 255)) - 128;
      default: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic mat_req_t diag(elem_t v);
    mat_req_t m;
    foreach (m.a[i]) m.a[i] = '0;
    m.a[0] = v; m.a[4] = v; m.a[8] = v;
    return m;
  endfunction

  initial begin
    mat_req_t m;
    int mode;
    pending_reqs.push_back(diag(32'sh0001_0000));
    pending_reqs.push_back(diag(32'sh0002_0000));
    pending_reqs.push_back(diag(-32'sh0001_0000));
    pending_reqs.push_back(diag(32'sh0000_0001));
    pending_reqs.push_back(diag(32'sh7FFF_FFFF));
    pending_reqs.push_back(diag(32'sh8000_0000));
    pending_reqs.push_back(diag(32'sh0000_0000));
    foreach (m.a[i]) m.a[i] = 32'sh7FFF_FFFF;
    pending_reqs.push_back(m);
    foreach (m.a[i]) m.a[i] = 32'sh8000_0000;
    pending_reqs.push_back(m);
    foreach (m.a[i]) m.a[i] = 32'shFFFF_FFFF;
    pending_reqs.push_back(m);
    m = diag(32'sh0001_0000); m.a[2] = 32'sh7FFF_FFFF; m.a[6] = 32'sh8000_0000;
    pending_reqs.push_back(m);
    m = diag(32'sh8000_0000); m.a[1] = 32'sh7FFF_FFFF; m.a[3] = 32'sh7FFF_FFFF;
    pending_reqs.push_back(m);
    for (int k = 0; k < 6; k++) begin
      foreach (m.a[i]) m.a[i] = elem_t'($urandom);
      m.a[6 + k % 3] = m.a[k % 3];
      m.a[3] = m.a[0]; m.a[4] = m.a[1]; m.a[5] = m.a[2];
      pending_reqs.push_back(m);
    end
    for (int k = 0; k < NRAND; k++) begin
      mode = $urandom_range(0, 9);
      mode = mode < 4 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3;
      foreach (m.a[i]) m.a[i] = ($urandom_range(0, 7) == 0) ? rand_elem(3) : rand_elem(mode);
      if ($urandom_range(0, 19) == 0) foreach (m.a[i]) if (i >= 6) m.a[i] = m.a[i - 3];
      pending_reqs.push_back(m);
    end
  end

  int sent = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;

  always @(posedge clk) begin
    mat_req_t m;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) sent <= sent + 1;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
      end else if (sent < NRAND - 200 && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(1, 16) - 1;
        req_valid <= 1'b0;
      end else begin
        m = pending_reqs.pop_front();
        expected_inv.push_back(invert(m));
        {a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
          {m.a[0], m.a[1], m.a[2], m.a[3], m.a[4], m.a[5], m.a[6], m.a[7], m.a[8]};
        req_valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (sent == 300 && hold_off == 0) begin
      hold_off <= 1;
      res_stall <= 1'b1;
    end else if (hold_off > 0 && hold_off < 200) begin
      hold_off <= hold_off + 1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      res_stall <= (recv_gap > 1);
    end else if (sent < NRAND - 200 && $urandom_range(0, 15) == 0) begin
      recv_gap <= $urandom_range(1, 16);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    inv_res_t e;
    elem_t got [9];
    if (!rst && res_valid && !res_stall) begin
      got = '{b00, b01, b02, b10, b11, b12, b20, b21, b22};
      if (expected_inv.size() == 0) begin
        $error("result with no pending request");
        errors++;
      end else begin
        e = expected_inv.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== e.b[i]) begin
            $error("b%0d%0d expected %h actual %h", i / 3, i % 3, e.b[i], got[i]);
            errors++;
          end
        if (singular !== e.sing) begin
          $error("singular expected %b actual %b", e.sing, singular);
          errors++;
        end
        if (overflowed !== e.ovf) begin
          $error("overflowed expected %b actual %b", e.ovf, overflowed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (!rst);
    while (pending_reqs.size() != 0 || req_valid || expected_inv.size() != 0) begin
      @(posedge clk);
      if (idle_cycles >= WDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_inv.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
